[src/multi_waveform_oscillator_top_assert.svh]
// ============================================================================
// Assertion macros for the multi-waveform oscillator
// Clocked implication checks shared by the oscillator's assertions.
// ============================================================================
`ifndef MULTI_WAVEFORM_OSCILLATOR_TOP_ASSERT_SVH
`define MULTI_WAVEFORM_OSCILLATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MWO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled during reset
`define MWO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[src/mwo_pkg.sv]
// ============================================================================
// mwo_pkg
// Shared types and constants of the multi-waveform oscillator.
// ============================================================================
package mwo_pkg;

    // Configuration port
    localparam int C_ADDR_W = 4;
    localparam int C_DATA_W = 32;

    localparam logic [1:0] C_REG_WAVE   = 2'd0;
    localparam logic [1:0] C_REG_GAIN   = 2'd1;
    localparam logic [1:0] C_REG_ENABLE = 2'd2;

    // Input and volume limits
    localparam logic [15:0] C_FREQ_MAX = 16'd64000;
    localparam logic [16:0] C_GAIN_MAX = 17'd65536;
    localparam logic [16:0] C_GAIN_RST = 17'd32768;

    // Wave shapes
    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_TRI    = 2'd3
    } t_wave;

    // Status of the iterative divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[src/mwo_sine_rom.sv]
// ============================================================================
// mwo_sine_rom
// Quarter-wave sine table, built at elaboration, read with a registered port.
// ============================================================================
module mwo_sine_rom #(
    parameter int TABLE_BITS = 10,
    parameter int SINE_PEAK  = 28000
) (
    input  logic                  i_clk,
    input  logic [TABLE_BITS:0]   i_addr,
    output logic [15:0]           o_data
);

    localparam int N_ENT = 2 ** TABLE_BITS;

    typedef logic [15:0] t_rom [0:N_ENT];

    // Taylor series of sin in Q30, every term truncated, scaled to the peak
    function automatic logic [15:0] f_quarter(input int k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic               stop;
        x    = (64'd1686629713 * 64'(k) + 64'(N_ENT / 2)) >> TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        stop = 1'b0;
        for (int n = 1; n < 16; n++) begin
            if (!stop) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (term == 64'd0) begin
                    stop = 1'b1;
                end else if ((n & 1) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        return 16'((64'(SINE_PEAK) * unsigned'(sum) + 64'd536870912) >> 30);
    endfunction

    function automatic t_rom f_build();
        t_rom rom;
        for (int k = 0; k <= N_ENT; k++) begin
            rom[k] = f_quarter(k);
        end
        return rom;
    endfunction

    localparam t_rom C_ROM = f_build();

    logic [15:0] r_data;

    // Registered table read
    always_ff @(posedge i_clk) begin
        r_data <= C_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

[src/mwo_div.sv]
// ============================================================================
// mwo_div
// Phase increment unit: inc = floor((f * 2^PHASE_BITS + DIVISOR/2) / DIVISOR),
// formed by reciprocal multiplication on one shared multiplier, then corrected.
// ============================================================================
module mwo_div #(
    parameter int PHASE_BITS = 32,
    parameter int DIVISOR    = 2822400
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [15:0]             i_freq,
    output logic [PHASE_BITS-1:0]   o_quo,
    output mwo_pkg::t_div_stat      o_stat
);

    import mwo_pkg::*;

    localparam int DW = $clog2(DIVISOR + 1);
    localparam int MW = 16 + DW;
    localparam int RW = DW + 2;

    // Split 2^P = Q*D + R0, so f*2^P + D/2 = f*Q*D + (f*R0 + D/2)
    localparam logic [31:0]   C_Q    = 32'((64'd1 << PHASE_BITS) / 64'(DIVISOR));
    localparam logic [31:0]   C_R0   = 32'((64'd1 << PHASE_BITS) % 64'(DIVISOR));
    // Reciprocal of the divisor scaled by 2^MW; the estimate is at most 2 low
    localparam logic [31:0]   C_M    = 32'((64'd1 << MW) / 64'(DIVISOR));
    localparam logic [31:0]   C_D    = 32'(DIVISOR);
    localparam logic [MW-1:0] C_HALF = MW'(DIVISOR / 2);
    localparam logic [RW-1:0] C_D1   = RW'(DIVISOR);
    localparam logic [RW-1:0] C_D2   = RW'(2 * DIVISOR);

    typedef enum logic [5:0] {
        D_IDLE = 6'b000001,
        D_BASE = 6'b000010,
        D_FRAC = 6'b000100,
        D_EST  = 6'b001000,
        D_REM  = 6'b010000,
        D_FIX  = 6'b100000
    } t_dstate;

    t_dstate r_state, n_state;

    logic [15:0]           r_f;
    logic [PHASE_BITS-1:0] r_base;
    logic [MW-1:0]         r_m;
    logic [16:0]           r_qe;
    logic [RW-1:0]         r_rem;
    logic [PHASE_BITS-1:0] r_quo;
    logic                  r_done;

    logic [16:0]           mul_a;
    logic [31:0]           mul_b;
    logic [48:0]           mul_p;
    logic [MW-1:0]         m_diff;
    logic [1:0]            fix;

    // Step sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE:  if (i_start) n_state = D_BASE;
            D_BASE:  n_state = D_FRAC;
            D_FRAC:  n_state = D_EST;
            D_EST:   n_state = D_REM;
            D_REM:   n_state = D_FIX;
            D_FIX:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    // Shared multiplier operands for each step
    always_comb begin
        unique case (r_state)
            D_BASE: begin
                mul_a = {1'b0, r_f};
                mul_b = C_Q;
            end
            D_FRAC: begin
                mul_a = {1'b0, r_f};
                mul_b = C_R0;
            end
            D_EST: begin
                mul_a = r_m[MW-1 -: 17];
                mul_b = C_M;
            end
            default: begin
                mul_a = r_qe;
                mul_b = C_D;
            end
        endcase
    end

    assign mul_p  = 49'(mul_a) * 49'(mul_b);
    assign m_diff = r_m - mul_p[MW-1:0];
    // Remainder lies below three divisors: add up to two to the estimate
    assign fix    = (r_rem >= C_D2) ? 2'd2 : ((r_rem >= C_D1) ? 2'd1 : 2'd0);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == D_IDLE && i_start) begin
                r_done <= 1'b0;
            end else if (r_state == D_FIX) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_f <= i_freq;
        end
        if (r_state == D_BASE) begin
            r_base <= mul_p[PHASE_BITS-1:0];
        end
        if (r_state == D_FRAC) begin
            r_m <= mul_p[MW-1:0] + C_HALF;
        end
        if (r_state == D_EST) begin
            r_qe <= mul_p[33:17];
        end
        if (r_state == D_REM) begin
            r_rem <= m_diff[RW-1:0];
        end
        if (r_state == D_FIX) begin
            r_quo <= r_base + PHASE_BITS'(r_qe) + PHASE_BITS'(fix);
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = (r_state != D_IDLE);
    assign o_stat.done = r_done;

endmodule

[src/multi_waveform_oscillator_top.sv]
// ============================================================================
// multi_waveform_oscillator_top
// Numerically controlled oscillator: sine, square, sawtooth and triangle.
// ============================================================================
// Usage:
// - Input channel (i_in_valid / o_in_stall / i_freq_hz): one item per sample
//   tick, carrying the frequency in unsigned Q10.6 Hz, clamped to 1000 Hz.
// - Output channel (o_out_valid / i_out_stall / o_sample): one signed 16-bit
//   sample per input item, formed from the phase before the update.
// - Config port (APB style): wave_select at 0x0, gain at 0x4 (Q1.16, capped
//   at unity), enable at 0x8. Write it only while no item is in flight.
// - The phase-increment unit steps through its base, fraction, estimate,
//   remainder and fix states after acceptance; the output register is then
//   loaded, and the next item is taken once the sequencer is back in idle.
// - Shaping and volume scaling share one 17x17 multiplier, used twice; the
//   phase increment comes from a 17x32 multiplier used over four steps.
// - The sample waits in an output register while the receiver stalls; the
//   next item is taken meanwhile and finishes once that register empties.
// - Reset clears the phase, selects sine, sets gain to one half and
//   disables the block; a disabled block emits 0 and holds the phase.
// ============================================================================
module multi_waveform_oscillator_top #(
    parameter int TICK_RATE_HZ    = 44100,
    parameter int SINE_PEAK       = 28000,
    parameter int RAMP_PEAK       = 32767,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [15:0]                   i_freq_hz,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [15:0]            o_sample,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwo_pkg::C_ADDR_W-1:0]  paddr,
    input  logic [mwo_pkg::C_DATA_W-1:0]  pwdata,
    output logic [mwo_pkg::C_DATA_W-1:0]  prdata,
    output logic                          pready
);

    import mwo_pkg::*;

    localparam int DIVISOR = TICK_RATE_HZ * 64;
    localparam int TB      = SINE_TABLE_BITS;

    localparam logic [16:0] C_RAMP = 17'(RAMP_PEAK);
    localparam logic [TB:0] C_NENT = {1'b1, {TB{1'b0}}};

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHAPE = 6'b000010,
        S_RAW   = 6'b000100,
        S_GAIN  = 6'b001000,
        S_SCALE = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    t_wave                 r_wave;
    logic [16:0]           r_gain;
    logic                  r_enable;
    logic [PHASE_BITS-1:0] r_phase;
    logic [33:0]           r_prod;
    logic [16:0]           r_mag;
    logic                  r_neg;
    logic [15:0]           r_samp;
    logic                  r_out_valid;
    logic [15:0]           r_out_sample;

    logic                  in_accept;
    logic                  cfg_wr;
    logic [1:0]            reg_idx;
    logic [15:0]           freq_sat;
    logic [16:0]           gain_sat;
    logic [15:0]           u;
    logic [1:0]            quad;
    logic [TB-1:0]         sidx;
    logic [TB:0]           rom_addr;
    logic [15:0]           rom_q;
    logic [16:0]           mul_a;
    logic [16:0]           mul_b;
    logic [33:0]           mul_p;
    logic [16:0]           raw_mag;
    logic [16:0]           scaled;
    logic                  w_load;
    logic [PHASE_BITS-1:0] div_quo;
    t_div_stat             div_stat;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave   <= WAVE_SINE;
            r_gain   <= C_GAIN_RST;
            r_enable <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                C_REG_WAVE:   r_wave   <= t_wave'(pwdata[1:0]);
                C_REG_GAIN:   r_gain   <= pwdata[16:0];
                C_REG_ENABLE: r_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            C_REG_WAVE:   prdata = C_DATA_W'(r_wave);
            C_REG_GAIN:   prdata = C_DATA_W'(r_gain);
            C_REG_ENABLE: prdata = C_DATA_W'(r_enable);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input handshake and clamps
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign freq_sat   = (i_freq_hz > C_FREQ_MAX) ? C_FREQ_MAX : i_freq_hz;
    assign gain_sat   = (r_gain > C_GAIN_MAX) ? C_GAIN_MAX : r_gain;

    // ------------------------------------------------------------------
    // Phase increment unit, started on each accepted item
    // ------------------------------------------------------------------
    mwo_div #(
        .PHASE_BITS (PHASE_BITS),
        .DIVISOR    (DIVISOR)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_freq  (freq_sat),
        .o_quo   (div_quo),
        .o_stat  (div_stat)
    );

    // ------------------------------------------------------------------
    // Sine table lookup from the current phase
    // ------------------------------------------------------------------
    assign u        = r_phase[PHASE_BITS-1 -: 16];
    assign quad     = r_phase[PHASE_BITS-1 -: 2];
    assign sidx     = r_phase[PHASE_BITS-3 -: TB];
    assign rom_addr = quad[0] ? (C_NENT - {1'b0, sidx}) : {1'b0, sidx};

    mwo_sine_rom #(
        .TABLE_BITS (TB),
        .SINE_PEAK  (SINE_PEAK)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_q)
    );

    // ------------------------------------------------------------------
    // Shared multiplier: ramp slope first, then the volume
    // ------------------------------------------------------------------
    always_comb begin
        if (r_state == S_SHAPE) begin
            mul_a = C_RAMP;
            mul_b = (r_wave == WAVE_TRI) ? {2'b00, u[14:0]} : {1'b0, u};
        end else begin
            mul_a = r_mag;
            mul_b = gain_sat;
        end
    end

    assign mul_p = mul_a * mul_b;

    // Raw magnitude of the selected shape
    always_comb begin
        unique case (r_wave)
            WAVE_SINE:   raw_mag = {1'b0, rom_q};
            WAVE_SQUARE: raw_mag = u[15] ? 17'd0 : C_RAMP;
            WAVE_SAW:    raw_mag = r_prod[32:16];
            WAVE_TRI:    raw_mag = u[15] ? (C_RAMP - r_prod[31:15]) : r_prod[31:15];
            default:     raw_mag = '0;
        endcase
    end

    assign scaled = r_prod[32:16];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_load = (r_state == S_WAIT) & div_stat.done & (~r_out_valid | ~i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_accept) n_state = S_SHAPE;
            S_SHAPE: n_state = S_RAW;
            S_RAW:   n_state = S_GAIN;
            S_GAIN:  n_state = S_SCALE;
            S_SCALE: n_state = S_WAIT;
            S_WAIT:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers of the shaping steps
    always_ff @(posedge i_clk) begin
        if (r_state == S_SHAPE || r_state == S_GAIN) begin
            r_prod <= mul_p;
        end
        if (r_state == S_RAW) begin
            r_mag <= raw_mag;
            r_neg <= (r_wave == WAVE_SINE) & quad[1];
        end
        if (r_state == S_SCALE) begin
            if (r_neg) begin
                r_samp <= 16'(-scaled);
            end else begin
                r_samp <= (scaled > 17'd32767) ? 16'h7FFF : scaled[15:0];
            end
        end
    end

    // Advance the phase when the item completes, if the block is enabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_load && r_enable) begin
            r_phase <= r_phase + div_quo;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_sample <= r_enable ? r_samp : 16'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = signed'(r_out_sample);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "multi_waveform_oscillator_top_assert.svh"

    `MWO_ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, !w_load, $stable(r_phase))
    `MWO_ASSERT_IMPL(a_valid_src, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == S_WAIT))
    `MWO_ASSERT_NEXT(a_mute, i_clk, i_rst_n, w_load && !r_enable, o_sample == 16'sd0)
    `MWO_ASSERT_IMPL(a_div_idle, i_clk, i_rst_n, r_state == S_IDLE, !div_stat.busy)

endmodule
